/* rtl/bpor_pkg.sv */
// Shared types and constants for the best-price order router.
// No dependencies.
package bpor_pkg;

	localparam int MaxQuotesDef = 16;
	localparam int ResultCap    = 16;
	localparam logic [20:0] SlipScale = 21'd1000000;

	typedef enum logic [1:0] {
		ST_FILLED  = 2'd0,
		ST_NOQUOTE = 2'd1,
		ST_PARTIAL = 2'd2
	} route_status_t;

	// one stored quote entry
	typedef struct packed {
		logic [7:0]         venue;
		logic [31:0]        bid;
		logic [31:0]        ask;
		logic [23:0]        bid_qty;
		logic [23:0]        ask_qty;
		logic signed [15:0] fee;
	} quote_t;

	// one order request queued between front and back
	typedef struct packed {
		logic [23:0] qty;
		logic        buy;
		logic [31:0] arrival;
	} order_t;

endpackage

/* rtl/bpor_div.sv */
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Uses no package items.
module bpor_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [79:0] num,
	input  logic signed [79:0] den,
	output logic               done,
	output logic signed [79:0] quo
);

	logic [79:0] n_q, d_q, r_q;
	logic [6:0]  cnt_q;
	logic        neg_q, run_q;
	logic [80:0] trial;
	logic [79:0] rsh;

	assign rsh   = {r_q[78:0], n_q[79]};
	assign trial = {1'b0, rsh} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				n_q   <= num[79] ? -num : num;
				d_q   <= den[79] ? -den : den;
				neg_q <= num[79] ^ den[79];
				r_q   <= '0;
				cnt_q <= 7'd80;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (!trial[80]) begin
					r_q <= trial[79:0];
					n_q <= {n_q[78:0], 1'b1};
				end else begin
					r_q <= rsh;
					n_q <= {n_q[78:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? -$signed(n_q) : $signed(n_q);

endmodule

/* rtl/bpor_front.sv */
// Front end: accepts requests, loads quotes, queues orders to the back end.
// Depends on bpor_pkg.
module bpor_front #(
	parameter int MAX_QUOTES = bpor_pkg::MaxQuotesDef,
	localparam int IW = (MAX_QUOTES > 1) ? $clog2(MAX_QUOTES) : 1,
	localparam int CW = $clog2(MAX_QUOTES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic                 req_type,
	input  bpor_pkg::quote_t     quote_in,
	input  bpor_pkg::order_t     order_in,
	input  logic                 deq,
	input  logic                 clr,
	input  logic [IW-1:0]        rd_idx,
	output bpor_pkg::quote_t     rd_quote,
	output logic                 ord_valid,
	output bpor_pkg::order_t     ord,
	output logic [CW-1:0]        count
);

	bpor_pkg::quote_t mem [MAX_QUOTES];
	logic [CW-1:0] count_q;

	// quote store, written in load order
	always_ff @(posedge clk) begin
		if (acc && !req_type && count_q < CW'(MAX_QUOTES))
			mem[count_q[IW-1:0]] <= quote_in;
		rd_quote <= mem[rd_idx];
	end

	// quote count and order queue of one entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ord_valid <= 1'b0;
		end else begin
			if (clr)
				count_q <= '0;
			else if (acc && !req_type && count_q < CW'(MAX_QUOTES))
				count_q <= count_q + CW'(1);
			if (acc && req_type) begin
				ord_valid <= 1'b1;
				ord       <= order_in;
			end else if (deq) begin
				ord_valid <= 1'b0;
			end
		end
	end

	assign count = count_q;

endmodule

/* rtl/bpor_back.sv */
// Back end: ranks quotes, walks fills, emits results and totals.
// Depends on bpor_pkg and bpor_div.
module bpor_back #(
	parameter int MAX_QUOTES = bpor_pkg::MaxQuotesDef,
	localparam int IW = (MAX_QUOTES > 1) ? $clog2(MAX_QUOTES) : 1,
	localparam int CW = $clog2(MAX_QUOTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ord_valid,
	input  bpor_pkg::order_t   ord,
	input  logic [CW-1:0]      count,
	input  bpor_pkg::quote_t   rd_quote,
	output logic [IW-1:0]      rd_idx,
	output logic               deq,
	output logic               clr,
	output logic               busy_back,
	output logic               done,
	output logic [7:0]         fill_venue,
	output logic [23:0]        exec_qty,
	output logic [31:0]        exec_price,
	output logic signed [57:0] fill_net_cost,
	output logic signed [31:0] fill_slippage,
	output logic               is_last,
	output logic signed [57:0] order_cost,
	output logic signed [33:0] avg_price,
	output logic signed [31:0] avg_slippage,
	output logic signed [31:0] vwap_deviation,
	output logic [1:0]         route_status
);

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN, S_SCANW, S_SCAN2, S_FILL, S_FILLW, S_FILLR, S_PROD,
		S_SLIPD, S_SLIPW, S_EMIT, S_AVG, S_AVGW, S_ASL, S_ASLW, S_VW,
		S_VWW, S_DEV, S_DEVW, S_FIN
	} st_t;

	st_t st_q;
	logic [MAX_QUOTES-1:0] used_q;
	logic [IW-1:0]  idx_q, best_q;
	logic [CW-1:0]  ptr_q;
	logic           have_q;
	logic signed [33:0] best_key_q;
	logic [23:0]    rem_q, t_q;
	logic [4:0]     nf_q;
	logic           first_q, pend_q;
	logic [31:0]    p_q;
	logic [7:0]     v_q;
	logic signed [15:0] fee_q;
	logic signed [57:0] net_q, cost_q;
	logic signed [31:0] slip_q;
	logic signed [63:0] sslip_q;
	logic [24:0]    qsum_q;
	logic [63:0]    vsum_q;
	logic [31:0]    ssum_q;
	logic signed [33:0] avg_q;
	logic signed [31:0] vwap_q;

	logic               dgo;
	logic signed [79:0] dnum, dden, dquo;
	logic               ddone;

	bpor_div u_div (.clk(clk), .arst_n(arst_n), .go(dgo), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo));

	logic [31:0] rp;
	logic [23:0] ra;
	logic signed [33:0] rkey;
	logic        rbetter;
	assign rp   = ord.buy ? rd_quote.ask : rd_quote.bid;
	assign ra   = ord.buy ? rd_quote.ask_qty : rd_quote.bid_qty;
	assign rkey = ord.buy ? $signed({2'b0, rp}) + 34'(rd_quote.fee)
	                      : $signed({2'b0, rp}) - 34'(rd_quote.fee);
	assign rbetter = !have_q || (ord.buy ? (rkey < best_key_q) : (rkey > best_key_q));

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		if (v > 80'sd2147483647) return 32'sh7fffffff;
		if (v < -80'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic [23:0] tmin;
	assign tmin = (ra < rem_q) ? ra : rem_q;

	// hold busy through the cycle the quote count clears
	assign busy_back = (st_q != S_IDLE) || clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			deq  <= 1'b0;
			clr  <= 1'b0;
			dgo  <= 1'b0;
		end else begin
			done <= 1'b0;
			deq  <= 1'b0;
			clr  <= 1'b0;
			dgo  <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (ord_valid && !deq) begin
						deq <= 1'b1;
						{fill_venue, exec_qty, exec_price} <= '0;
						fill_net_cost <= '0; fill_slippage <= '0;
						order_cost <= '0; avg_price <= '0;
						avg_slippage <= '0; vwap_deviation <= '0;
						if (count == '0) begin
							is_last <= 1'b1;
							route_status <= bpor_pkg::ST_NOQUOTE;
							done <= 1'b1;
						end else begin
							route_status <= bpor_pkg::ST_FILLED;
							used_q <= '0; rem_q <= ord.qty; nf_q <= '0;
							cost_q <= '0; sslip_q <= '0; qsum_q <= '0;
							vsum_q <= '0; ssum_q <= '0; first_q <= 1'b1;
							pend_q <= 1'b0; ptr_q <= '0;
							rd_idx <= '0;
							st_q <= S_SCAN;
						end
					end
				end
				// vwap sums pass over the stored quotes, one read at a time
				S_SCAN: begin
					st_q <= S_SCANW;
				end
				S_SCANW: begin
					vsum_q <= vsum_q + 64'(rp) * 64'(ra);
					ssum_q <= ssum_q + 32'(ra);
					if (ptr_q + CW'(1) == count) begin
						st_q <= S_FILL;
					end else begin
						rd_idx <= rd_idx + IW'(1);
						st_q <= S_SCAN;
					end
					ptr_q <= ptr_q + CW'(1);
				end
				S_SCAN2: st_q <= S_FILL;
				// pick next best unused quote by linear search
				S_FILL: begin
					if ((rem_q == '0 && !first_q) || nf_q == 5'(bpor_pkg::ResultCap)
						|| (!first_q && &used_q[0 +: 1] && 1'b0)) begin
						st_q <= S_AVG;
					end else begin
						have_q <= 1'b0; idx_q <= '0; rd_idx <= '0;
						st_q <= S_FILLW;
					end
				end
				S_FILLW: st_q <= S_FILLR;
				S_FILLR: begin
					if (!used_q[idx_q] && rbetter) begin
						have_q <= 1'b1; best_key_q <= rkey; best_q <= idx_q;
					end
					if (32'(idx_q) + 1 == 32'(count)) begin
						if (!have_q && (used_q[idx_q] || !rbetter)) begin
							st_q <= S_AVG;
						end else begin
							rd_idx <= (!used_q[idx_q] && rbetter) ? idx_q : best_q;
							st_q <= S_PROD;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
						rd_idx <= idx_q + IW'(1);
						st_q <= S_FILLW;
					end
					pend_q <= 1'b0;
				end
				S_PROD: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						used_q[rd_idx] <= 1'b1;
						if (first_q && ra >= rem_q) begin
							t_q <= rem_q;
						end else begin
							t_q <= tmin;
						end
						p_q <= rp; v_q <= rd_quote.venue; fee_q <= rd_quote.fee;
						if (!(first_q && ra >= rem_q) && tmin == '0) begin
							first_q <= 1'b0;
							st_q <= S_FILL;
						end else begin
							st_q <= S_SLIPD;
						end
					end
				end
				S_SLIPD: begin
					net_q <= (ord.buy ? 58'sd0 + $signed({26'b0, p_q}) * $signed({34'b0, t_q})
					                  : 58'sd0 - $signed({26'b0, p_q}) * $signed({34'b0, t_q}))
					         + 58'(fee_q) * $signed({34'b0, t_q});
					dnum <= 80'((ord.buy ? $signed({1'b0, p_q}) - $signed({1'b0, ord.arrival})
					                     : $signed({1'b0, ord.arrival}) - $signed({1'b0, p_q})))
					        * 80'sd1000000;
					dden <= $signed({48'b0, ord.arrival});
					pend_q <= 1'b0;
					if (ord.arrival != '0) begin
						dgo <= 1'b1;
						st_q <= S_SLIPW;
					end else begin
						slip_q <= '0;
						st_q <= S_EMIT;
					end
				end
				S_SLIPW: if (ddone) begin
					slip_q <= sat32(dquo);
					st_q <= S_EMIT;
				end
				S_EMIT: begin
					if (nf_q != '0 && !pend_q) begin
						// strobe the held fill before loading the new one
						done <= 1'b1;
						pend_q <= 1'b1;
					end else begin
						fill_venue <= v_q; exec_qty <= t_q; exec_price <= p_q;
						fill_net_cost <= net_q; fill_slippage <= slip_q;
						is_last <= 1'b0;
						cost_q <= cost_q + net_q;
						qsum_q <= qsum_q + 25'(t_q);
						sslip_q <= sslip_q + 64'(slip_q) * $signed({40'b0, t_q});
						nf_q <= nf_q + 5'd1;
						rem_q <= rem_q - t_q;
						pend_q <= 1'b1;
						first_q <= 1'b0;
						if (first_q && t_q == ord.qty) begin
							st_q <= S_AVG;
						end else begin
							st_q <= S_FILL;
						end
					end
				end
				S_AVG: begin
					if (qsum_q != '0) begin
						dnum <= 80'(cost_q); dden <= 80'(qsum_q); dgo <= 1'b1;
						st_q <= S_AVGW;
					end else begin
						avg_q <= '0;
						st_q <= S_FIN;
					end
				end
				S_AVGW: if (ddone) begin
					avg_q <= dquo[33:0];
					dnum <= 80'(sslip_q); dden <= 80'(qsum_q); dgo <= 1'b1;
					st_q <= S_ASLW;
				end
				S_ASLW: if (ddone) begin
					avg_slippage <= sat32(dquo);
					dnum <= 80'(vsum_q); dden <= 80'(ssum_q);
					if (ssum_q != '0) begin
						dgo <= 1'b1;
						st_q <= S_VWW;
					end else begin
						vwap_q <= '0;
						st_q <= S_DEV;
					end
				end
				S_VWW: if (ddone) begin
					vwap_q <= dquo[31:0];
					st_q <= S_DEV;
				end
				S_DEV: begin
					if (vwap_q != '0) begin
						dnum <= ((avg_q < 0) ? 80'(-avg_q) : 80'(avg_q))
						        - $signed({48'b0, vwap_q});
						dden <= $signed({48'b0, vwap_q});
						st_q <= S_DEVW;
						pend_q <= 1'b0;
					end else begin
						vwap_deviation <= '0;
						st_q <= S_FIN;
					end
				end
				S_DEVW: begin
					if (!pend_q) begin
						dnum <= dnum * 80'sd1000000;
						dgo <= 1'b1;
						pend_q <= 1'b1;
					end else if (ddone) begin
						vwap_deviation <= sat32(dquo);
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					// last result carries totals; hold pending fill if any
					if (nf_q == '0) begin
						{fill_venue, exec_qty, exec_price} <= '0;
						fill_net_cost <= '0; fill_slippage <= '0;
					end
					is_last <= 1'b1;
					order_cost <= cost_q;
					avg_price <= avg_q;
					route_status <= (qsum_q == 25'(ord.qty)) ? bpor_pkg::ST_FILLED
					                                           : bpor_pkg::ST_PARTIAL;
					done <= 1'b1;
					clr <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/best_price_order_router.sv */
// Best-price order router. A quote request is taken every cycle while busy is
// low. An order holds busy through the vwap scan, each fill and the totals, paced
// by the shared divider and the one-read quote store; busy drops in the cycle
// after the last result.
// Results are strobed one at a time; the receiver cannot stall them.
// Reset clears the quote count and all control; quote entries are not cleared.
module best_price_order_router #(
	parameter int MAX_QUOTES = bpor_pkg::MaxQuotesDef,
	localparam int IW = (MAX_QUOTES > 1) ? $clog2(MAX_QUOTES) : 1,
	localparam int CW = $clog2(MAX_QUOTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [7:0]         venue_id,
	input  logic [31:0]        bid_price,
	input  logic [31:0]        ask_price,
	input  logic [23:0]        bid_qty,
	input  logic [23:0]        ask_qty,
	input  logic signed [15:0] share_fee,
	input  logic [23:0]        order_qty,
	input  logic               order_is_buy,
	input  logic [31:0]        ref_price,
	output logic               strobe,
	output logic [7:0]         fill_venue,
	output logic [23:0]        exec_qty,
	output logic [31:0]        exec_price,
	output logic signed [57:0] fill_net_cost,
	output logic signed [31:0] fill_slippage,
	output logic               is_last,
	output logic signed [57:0] order_cost,
	output logic signed [33:0] avg_price,
	output logic signed [31:0] avg_slippage,
	output logic signed [31:0] vwap_deviation,
	output logic [1:0]         route_status
);

	bpor_pkg::quote_t qin, rdq;
	bpor_pkg::order_t oin, ord;
	logic acc, deq, clr, ordv, bb;
	logic [IW-1:0] ridx;
	logic [CW-1:0] cnt;

	assign qin = '{venue: venue_id, bid: bid_price, ask: ask_price,
		bid_qty: bid_qty, ask_qty: ask_qty, fee: share_fee};
	assign oin = '{qty: order_qty, buy: order_is_buy, arrival: ref_price};
	assign busy = ordv || bb;
	assign acc  = start && !busy;

	bpor_front #(.MAX_QUOTES(MAX_QUOTES)) u_front (
		.clk(clk), .arst_n(arst_n), .acc(acc), .req_type(req_type),
		.quote_in(qin), .order_in(oin), .deq(deq), .clr(clr), .rd_idx(ridx),
		.rd_quote(rdq), .ord_valid(ordv), .ord(ord), .count(cnt));

	bpor_back #(.MAX_QUOTES(MAX_QUOTES)) u_back (
		.clk(clk), .arst_n(arst_n), .ord_valid(ordv), .ord(ord), .count(cnt),
		.rd_quote(rdq), .rd_idx(ridx), .deq(deq), .clr(clr), .busy_back(bb),
		.done(strobe), .fill_venue(fill_venue), .exec_qty(exec_qty),
		.exec_price(exec_price), .fill_net_cost(fill_net_cost),
		.fill_slippage(fill_slippage), .is_last(is_last), .order_cost(order_cost),
		.avg_price(avg_price), .avg_slippage(avg_slippage),
		.vwap_deviation(vwap_deviation), .route_status(route_status));

endmodule

/* tb/tb.sv */
// Self-checking testbench for best_price_order_router: drives quote and order
// requests, predicts every fill and checks each strobed result in order.
// Depends on rtl/bpor_pkg.sv and rtl/best_price_order_router.sv.
module tb;

	localparam int StoreDepth = 16;
	localparam int FillLimit  = 16;
	localparam int Stall      = 20000;
	localparam bit REQ_QUOTE  = 1'b0;
	localparam bit REQ_ORDER  = 1'b1;

	typedef struct {
		bit                 rt;
		bit [7:0]           venue;
		bit [31:0]          bid;
		bit [31:0]          ask;
		bit [23:0]          bq;
		bit [23:0]          aq;
		bit signed [15:0]   fee;
		bit [23:0]          oq;
		bit                 buy;
		bit [31:0]          arr;
	} request_t;

	typedef struct packed {
		logic [7:0]         venue;
		logic [23:0]        qty;
		logic [31:0]        price;
		logic signed [57:0] net;
		logic signed [31:0] slip;
		logic               last;
		logic signed [57:0] total;
		logic signed [33:0] avg;
		logic signed [31:0] aslip;
		logic signed [31:0] dev;
		logic [1:0]         status;
	} fill_t;

	class fill_scoreboard;
		bpor_pkg::quote_t book[StoreDepth];
		int unsigned depth;
		fill_t       fills_due[$];
		int          fails;

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint side_price(int i, bit buy);
			return buy ? longint'(book[i].ask) : longint'(book[i].bid);
		endfunction

		function longint side_size(int i, bit buy);
			return buy ? longint'(book[i].ask_qty) : longint'(book[i].bid_qty);
		endfunction

		// fee-adjusted rank: lower wins for a buy, higher for a sell
		function bit ranks_ahead(int a, int b, bit buy);
			if (buy)
				return side_price(a, 1) + longint'(book[a].fee) <
					side_price(b, 1) + longint'(book[b].fee);
			return side_price(a, 0) - longint'(book[a].fee) >
				side_price(b, 0) - longint'(book[b].fee);
		endfunction

		function void note_request(request_t r);
			int rank[StoreDepth];
			int pick[FillLimit];
			longint take[FillLimit];
			int nf, j;
			longint rem, t, p, net, slip, cost, qsum, ssum_slip, avg, dev;
			longint unsigned vsum, zsum;
			fill_t f;
			nf = 0; cost = 0; qsum = 0; ssum_slip = 0; vsum = 0; zsum = 0;
			if (r.rt == REQ_QUOTE) begin
				if (depth < StoreDepth) begin
					book[depth] = '{r.venue, r.bid, r.ask, r.bq, r.aq, r.fee};
					depth++;
				end
				return;
			end
			f = '0;
			if (depth == 0) begin
				f.last = 1'b1;
				f.status = bpor_pkg::ST_NOQUOTE;
				fills_due.insert(fills_due.size(), f);
				return;
			end
			for (int i = 0; i < depth; i++) begin
				j = i;
				while (j > 0 && ranks_ahead(i, rank[j-1], r.buy)) begin
					rank[j] = rank[j-1];
					j--;
				end
				rank[j] = i;
			end
			if (side_size(rank[0], r.buy) >= longint'(r.oq)) begin
				pick[0] = rank[0];
				take[0] = r.oq;
				nf = 1;
			end else begin
				rem = r.oq;
				for (int i = 0; i < depth && rem > 0 && nf < FillLimit; i++) begin
					t = side_size(rank[i], r.buy);
					if (t > rem) t = rem;
					if (t > 0) begin
						pick[nf] = rank[i];
						take[nf] = t;
						nf++;
						rem -= t;
					end
				end
			end
			for (int i = 0; i < depth; i++) begin
				vsum += longint'(side_price(i, r.buy)) * side_size(i, r.buy);
				zsum += side_size(i, r.buy);
			end
			for (int k = 0; k < nf; k++) begin
				p = side_price(pick[k], r.buy);
				net = (r.buy ? p * take[k] : -(p * take[k])) +
					longint'(book[pick[k]].fee) * take[k];
				slip = 0;
				if (r.arr > 0)
					slip = sat32((r.buy ? p - longint'(r.arr) : longint'(r.arr) - p) *
						1000000 / longint'(r.arr));
				cost += net;
				qsum += take[k];
				ssum_slip += slip * take[k];
				f = '0;
				f.venue = book[pick[k]].venue;
				f.qty = take[k][23:0];
				f.price = p[31:0];
				f.net = net[57:0];
				f.slip = slip[31:0];
				if (k == nf - 1) begin
					// hold totals for the closing fill
					f.last = 1'b1;
					f.total = cost[57:0];
				end
				fills_due.insert(fills_due.size(), f);
			end
			if (nf == 0) begin
				f = '0;
				fills_due.insert(fills_due.size(), f);
			end
			f = fills_due.pop_back();
			f.last = 1'b1;
			f.total = cost[57:0];
			avg = 0; slip = 0; dev = 0;
			if (qsum > 0) begin
				avg = cost / qsum;
				slip = sat32(ssum_slip / qsum);
				p = zsum ? longint'(vsum / zsum) : 0;
				if (p > 0)
					dev = sat32(((avg < 0 ? -avg : avg) - p) * 1000000 / p);
			end
			f.avg = avg[33:0];
			f.aslip = slip[31:0];
			f.dev = dev[31:0];
			f.status = (qsum == longint'(r.oq)) ? bpor_pkg::ST_FILLED : bpor_pkg::ST_PARTIAL;
			fills_due.insert(fills_due.size(), f);
			depth = 0;
		endfunction

		function void field(string name, longint e, longint a);
			if (e != a) begin
				fails++;
				$display("%0t: %s expected %0d actual %0d", $time, name, e, a);
			end
		endfunction

		function void check(fill_t a);
			fill_t e;
			if (fills_due.size() == 0) begin
				fails++;
				$display("%0t: unexpected fill, expected none actual %p", $time, a);
				return;
			end
			e = fills_due.pop_front();
			field("fill_venue", e.venue, a.venue);
			field("exec_qty", e.qty, a.qty);
			field("exec_price", e.price, a.price);
			field("fill_net_cost", e.net, a.net);
			field("fill_slippage", e.slip, a.slip);
			field("is_last", e.last, a.last);
			field("order_cost", e.total, a.total);
			field("avg_price", e.avg, a.avg);
			field("avg_slippage", e.aslip, a.aslip);
			field("vwap_deviation", e.dev, a.dev);
			field("route_status", e.status, a.status);
		endfunction
	endclass

	logic               clk, arst_n, start, busy, strobe;
	logic               req_type, order_is_buy, is_last;
	logic [7:0]         venue_id, fill_venue;
	logic [31:0]        bid_price, ask_price, ref_price, exec_price;
	logic [23:0]        bid_qty, ask_qty, order_qty, exec_qty;
	logic signed [15:0] share_fee;
	logic signed [57:0] fill_net_cost, order_cost;
	logic signed [31:0] fill_slippage, avg_slippage, vwap_deviation;
	logic signed [33:0] avg_price;
	logic [1:0]         route_status;

	fill_scoreboard sb = new();
	bit quiet;
	int sent;
	int idle_count;

	best_price_order_router dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (strobe)
			sb.check('{fill_venue, exec_qty, exec_price, fill_net_cost, fill_slippage,
				is_last, order_cost, avg_price, avg_slippage, vwap_deviation,
				route_status});
	end

	// watchdog on cycles with neither a request nor a fill
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_count <= 0;
		else if (idle_count >= Stall) begin
			$display("best_price_order_router verification failed");
			$finish;
		end else
			idle_count <= idle_count + 1;
	end

	task automatic send(request_t r);
		while (!quiet && $urandom_range(99) < 7) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= r.rt;
		venue_id <= r.venue;
		bid_price <= r.bid;
		ask_price <= r.ask;
		bid_qty <= r.bq;
		ask_qty <= r.aq;
		share_fee <= r.fee;
		order_qty <= r.oq;
		order_is_buy <= r.buy;
		ref_price <= r.arr;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.fills_due.size() != 0) @(posedge clk);
	endtask

	function automatic bit [31:0] any32();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 100);
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [23:0] any24();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 500));
		endcase
	endfunction

	function automatic request_t quote(bit [7:0] v, bit [31:0] b, bit [31:0] a,
			bit [23:0] bq, bit [23:0] aq, bit signed [15:0] fee);
		request_t r;
		r = '{REQ_QUOTE, v, b, a, bq, aq, fee, 24'($urandom), 1'($urandom), $urandom};
		return r;
	endfunction

	function automatic request_t order(bit [23:0] q, bit buy, bit [31:0] arr);
		request_t r;
		r = '{REQ_ORDER, 8'($urandom), $urandom, $urandom, 24'($urandom), 24'($urandom),
			16'($urandom), q, buy, arr};
		return r;
	endfunction

	function automatic request_t rand_quote();
		bit signed [15:0] fee;
		case ($urandom_range(5))
			0: fee = 16'sh8000;
			1: fee = 16'sh7fff;
			default: fee = 16'($urandom);
		endcase
		return quote(8'($urandom), any32(), any32(), any24(), any24(), fee);
	endfunction

	initial begin
		int nq;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_QUOTE;
		venue_id = '0;
		bid_price = '0;
		ask_price = '0;
		bid_qty = '0;
		ask_qty = '0;
		share_fee = '0;
		order_qty = '0;
		order_is_buy = 1'b0;
		ref_price = '0;
		idle_count = 0;
		quiet = 1'b0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// order against an empty store
		send(order(24'd100, 1'b1, 32'd5000));
		// fill the store past capacity; small sizes force the sixteen-fill limit
		for (int i = 0; i < StoreDepth + 1; i++)
			send(quote(8'(i), (i % 2) ? 32'hffff_ffff : 32'(i),
				(i % 3) ? 32'd0 : 32'hffff_ffff,
				24'(i + 1), (i == 4) ? 24'hff_ffff : 24'd2,
				(i % 2) ? 16'sh8000 : 16'sh7fff));
		send(order(24'hff_ffff, 1'b0, 32'hffff_ffff));
		// no shares on the buy side
		send(quote(8'd7, 32'd100, 32'd200, 24'd50, 24'd0, 16'sd3));
		send(order(24'd10, 1'b1, 32'd150));
		// equal fee-adjusted prices, zero quantity
		send(quote(8'd1, 32'd990, 32'd1000, 24'd10, 24'd10, 16'sd0));
		send(quote(8'd2, 32'd991, 32'd1001, 24'd10, 24'd10, -16'sd1));
		send(order(24'd0, 1'b1, 32'd0));
		drain();

		while (sent < 100) begin
			quiet = (sent > 60 && sent < 95);
			nq = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
			for (int i = 0; i < nq; i++)
				send(rand_quote());
			send(order(($urandom_range(7) == 0) ? any24() : 24'($urandom_range(0, 1200)),
				1'($urandom_range(1)), any32()));
		end

		drain();
		repeat (300) @(posedge clk);
		if (sb.fails == 0 && sb.fills_due.size() == 0)
			$display("best_price_order_router verification clean");
		else
			$display("best_price_order_router verification failed");
		$finish;
	end
endmodule
